>>> hdl/msog_pkg.sv
package msog_pkg;

    localparam int MAX_DIM = 16;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int SEQ_W   = $clog2(MAX_DIM * MAX_DIM);
    localparam int TOT_W   = SEQ_W + 1;
    // Signed position word: holds -1 and the widest diagonal start (2*MAX_DIM-1).
    localparam int POS_W   = $clog2(2 * MAX_DIM) + 2;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam logic [DIM_W-1:0] ROW_COUNT_RST = DIM_W'(8);
    localparam logic [DIM_W-1:0] COL_COUNT_RST = DIM_W'(8);

    typedef logic signed [POS_W-1:0] t_pos;

    typedef enum logic [2:0] {
        MODE_RASTER   = 3'd0,
        MODE_SPIRAL   = 3'd1,
        MODE_SNAKE    = 3'd2,
        MODE_ZIG_RIGHT = 3'd3,
        MODE_ZIG_DOWN = 3'd4
    } t_scan_mode;

    typedef enum logic [1:0] {
        LEG_RIGHT = 2'd0,
        LEG_DOWN  = 2'd1,
        LEG_LEFT  = 2'd2,
        LEG_UP    = 2'd3
    } t_leg;

    typedef enum logic [1:0] {
        REG_ROW_COUNT   = 2'd0,
        REG_COL_COUNT   = 2'd1,
        REG_START_VALUE = 2'd2,
        REG_SCAN_MODE   = 2'd3
    } t_reg_addr;

    // A zero size counts as one, anything above the largest size as the largest.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

>>> hdl/matrix_scan_order_generator_top.sv
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+---------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_restart
// result   | o_out_valid  | i_out_stall  | o_row_index o_col_index o_cell_value o_last_cell
// config   | psel/penable | pready       | pwrite paddr pwdata prdata
//
// One input beat gives one result beat; a new beat is taken every cycle unless input stalls.
// The next cell is worked out from the position registers in the cycle of
// acceptance and appears on the result outputs in the next cycle.
// Input stalls only while the result register is full and its beat is stalled.
// Synchronous active-low reset; the first beat after reset starts a new scan.
module matrix_scan_order_generator_top
    import msog_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_restart,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic signed [DATA_W-1:0] o_cell_value,
    output logic                     o_last_cell,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    logic [DIM_W-1:0]         r_row_count;
    logic [DIM_W-1:0]         r_col_count;
    logic signed [DATA_W-1:0] r_start_value;
    logic [2:0]               r_scan_mode;

    logic [IDX_W-1:0]         r_cur_row, n_cur_row;
    logic [IDX_W-1:0]         r_cur_col, n_cur_col;
    logic [SEQ_W-1:0]         r_seq_index, n_seq_index;
    logic [IDX_W-1:0]         r_ring_level, n_ring_level;
    t_leg                     r_leg_dir, n_leg_dir;
    logic                     r_started;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_row_index;
    logic [IDX_W-1:0]         r_col_index;
    logic signed [DATA_W-1:0] r_cell_value;
    logic                     r_last_cell;

    logic                     w_cfg_wr;
    logic                     w_in_fire;
    t_scan_mode               w_mode;
    logic [DIM_W-1:0]         w_cols;
    logic [DIM_W-1:0]         w_rows;
    logic [TOT_W-1:0]         w_total;
    logic                     w_fresh;
    logic                     w_ok;
    t_pos                     w_r;
    t_pos                     w_c;
    t_leg                     w_leg;
    logic [IDX_W-1:0]         w_ring;
    logic [DATA_W-1:0]        w_cell_value;
    logic                     w_last_cell;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_fire   = i_in_valid && !o_in_stall;

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_row_index;
    assign o_col_index  = r_col_index;
    assign o_cell_value = r_cell_value;
    assign o_last_cell  = r_last_cell;

    always_comb begin
        case (t_reg_addr'(paddr[3:2]))
            REG_ROW_COUNT:   prdata = DATA_W'(r_row_count);
            REG_COL_COUNT:   prdata = DATA_W'(r_col_count);
            REG_START_VALUE: prdata = r_start_value;
            REG_SCAN_MODE:   prdata = DATA_W'(r_scan_mode);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= ROW_COUNT_RST;
            r_col_count   <= COL_COUNT_RST;
            r_start_value <= '0;
            r_scan_mode   <= MODE_RASTER;
        end else if (w_cfg_wr) begin
            case (t_reg_addr'(paddr[3:2]))
                REG_ROW_COUNT:   r_row_count   <= pwdata[DIM_W-1:0];
                REG_COL_COUNT:   r_col_count   <= pwdata[DIM_W-1:0];
                REG_START_VALUE: r_start_value <= pwdata;
                REG_SCAN_MODE:   r_scan_mode   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Effective sizes and mode; unknown mode codes scan in raster order.
    always_comb begin
        case (r_scan_mode)
            MODE_SPIRAL:    w_mode = MODE_SPIRAL;
            MODE_SNAKE:     w_mode = MODE_SNAKE;
            MODE_ZIG_RIGHT: w_mode = MODE_ZIG_RIGHT;
            MODE_ZIG_DOWN:  w_mode = MODE_ZIG_DOWN;
            default:        w_mode = MODE_RASTER;
        endcase
        w_cols  = clamp_dim(r_col_count);
        w_rows  = (w_mode == MODE_SPIRAL) ? w_cols : clamp_dim(r_row_count);
        w_total = TOT_W'(w_rows) * TOT_W'(w_cols);
    end

    // Next position from the current one.
    always_comb begin
        t_pos r;
        t_pos c;
        t_pos rows_s;
        t_pos cols_s;
        t_pos lv;
        t_pos hi;
        t_pos d;
        logic down_left;

        r         = t_pos'({1'b0, r_cur_row});
        c         = t_pos'({1'b0, r_cur_col});
        rows_s    = t_pos'({1'b0, w_rows});
        cols_s    = t_pos'({1'b0, w_cols});
        lv        = t_pos'({1'b0, r_ring_level});
        hi        = cols_s - t_pos'(1) - lv;
        d         = r + c;
        down_left = (d[0] == 1'b1) == (w_mode == MODE_ZIG_RIGHT);
        w_ok      = 1'b1;
        w_leg     = r_leg_dir;
        w_ring    = r_ring_level;

        case (w_mode)
            MODE_SPIRAL: begin
                if (hi < lv) begin
                    w_ok = 1'b0;
                end else begin
                    case (r_leg_dir)
                        LEG_RIGHT: begin
                            if (c < hi) begin
                                c = c + t_pos'(1);
                            end else begin
                                w_leg = LEG_DOWN;
                                r = r + t_pos'(1);
                            end
                        end
                        LEG_DOWN: begin
                            if (r < hi) begin
                                r = r + t_pos'(1);
                            end else begin
                                w_leg = LEG_LEFT;
                                c = c - t_pos'(1);
                            end
                        end
                        LEG_LEFT: begin
                            if (c > lv) begin
                                c = c - t_pos'(1);
                            end else begin
                                w_leg = LEG_UP;
                                r = r - t_pos'(1);
                            end
                        end
                        default: begin
                            // Going up stops one row below the ring's top, then
                            // the walk steps right into the next inner ring.
                            if (r > lv + t_pos'(1)) begin
                                r = r - t_pos'(1);
                            end else begin
                                w_ring = r_ring_level + IDX_W'(1);
                                w_leg  = LEG_RIGHT;
                                c = c + t_pos'(1);
                            end
                        end
                    endcase
                end
            end
            MODE_SNAKE: begin
                if (r[0] == 1'b0) begin
                    if (c < cols_s - t_pos'(1)) c = c + t_pos'(1);
                    else                        r = r + t_pos'(1);
                end else begin
                    if (c > t_pos'(0)) c = c - t_pos'(1);
                    else               r = r + t_pos'(1);
                end
            end
            MODE_ZIG_RIGHT, MODE_ZIG_DOWN: begin
                if (down_left && c > t_pos'(0) && r + t_pos'(1) < rows_s) begin
                    r = r + t_pos'(1);
                    c = c - t_pos'(1);
                end else if (!down_left && r > t_pos'(0) && c + t_pos'(1) < cols_s) begin
                    r = r - t_pos'(1);
                    c = c + t_pos'(1);
                end else begin
                    // Jump to the first in-range cell of the next diagonal.
                    d = d + t_pos'(1);
                    if (down_left) begin
                        r = (d < rows_s - t_pos'(1)) ? d : rows_s - t_pos'(1);
                        c = d - r;
                    end else begin
                        c = (d < cols_s - t_pos'(1)) ? d : cols_s - t_pos'(1);
                        r = d - c;
                    end
                end
            end
            default: begin
                if (c < cols_s - t_pos'(1)) begin
                    c = c + t_pos'(1);
                end else begin
                    c = '0;
                    r = r + t_pos'(1);
                end
            end
        endcase

        if (r < t_pos'(0) || c < t_pos'(0) || r >= rows_s || c >= cols_s) begin
            w_ok = 1'b0;
        end
        w_r = r;
        w_c = c;
    end

    always_comb begin
        w_fresh = i_restart || !r_started || !w_ok
                  || ({1'b0, r_seq_index} + TOT_W'(1) >= w_total);
        if (w_fresh) begin
            n_cur_row    = '0;
            n_cur_col    = '0;
            n_seq_index  = '0;
            n_ring_level = '0;
            n_leg_dir    = LEG_RIGHT;
        end else begin
            n_cur_row    = w_r[IDX_W-1:0];
            n_cur_col    = w_c[IDX_W-1:0];
            n_seq_index  = r_seq_index + SEQ_W'(1);
            n_ring_level = w_ring;
            n_leg_dir    = w_leg;
        end
        w_cell_value = r_start_value + DATA_W'(n_seq_index);
        w_last_cell  = ({1'b0, n_seq_index} + TOT_W'(1)) == w_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_seq_index  <= '0;
            r_ring_level <= '0;
            r_leg_dir    <= LEG_RIGHT;
            r_started    <= 1'b0;
        end else if (w_in_fire) begin
            r_cur_row    <= n_cur_row;
            r_cur_col    <= n_cur_col;
            r_seq_index  <= n_seq_index;
            r_ring_level <= n_ring_level;
            r_leg_dir    <= n_leg_dir;
            r_started    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_row_index  <= n_cur_row;
            r_col_index  <= n_cur_col;
            r_cell_value <= w_cell_value;
            r_last_cell  <= w_last_cell;
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import msog_pkg::*;

    localparam logic [2:0] UNKNOWN_MODE = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_cell_beat;

    // Shadow of the generator: register copies, scan position and the cells still owed.
    class scan_scoreboard;
        logic [DIM_W-1:0]  rows_reg;
        logic [DIM_W-1:0]  cols_reg;
        logic [DATA_W-1:0] start_reg;
        logic [2:0]        mode_reg;
        logic [IDX_W-1:0]  row_pos;
        logic [IDX_W-1:0]  col_pos;
        logic [TOT_W-1:0]  seq;
        logic [IDX_W-1:0]  ring;
        t_leg              leg;
        logic [4:0]        diag;
        bit                begun;
        t_cell_beat        pending[$];
        int                errors;

        function new();
            rows_reg  = ROW_COUNT_RST;
            cols_reg  = COL_COUNT_RST;
            start_reg = '0;
            mode_reg  = MODE_RASTER;
            row_pos   = '0;
            col_pos   = '0;
            seq       = '0;
            ring      = '0;
            leg       = LEG_RIGHT;
            diag      = '0;
            begun     = 1'b0;
            errors    = 0;
        endfunction

        function void set_register(t_reg_addr which, logic [DATA_W-1:0] value);
            case (which)
                REG_ROW_COUNT:   rows_reg  = value[DIM_W-1:0];
                REG_COL_COUNT:   cols_reg  = value[DIM_W-1:0];
                REG_START_VALUE: start_reg = value;
                default:         mode_reg  = value[2:0];
            endcase
        endfunction

        function int used_dim(logic [DIM_W-1:0] v);
            if (v == '0) begin
                return 1;
            end
            if (int'(v) > MAX_DIM) begin
                return MAX_DIM;
            end
            return int'(v);
        endfunction

        // Steps from the current cell; returns 0 when the step leaves the matrix or no spiral ring is left.
        function bit advance(t_scan_mode scan, int rows, int cols,
                             output int r_out, output int c_out);
            int r;
            int c;
            int lv;
            int hi;
            int d;
            bit down_left;
            r = int'(row_pos);
            c = int'(col_pos);
            r_out = 0;
            c_out = 0;
            case (scan)
                MODE_SPIRAL: begin
                    lv = int'(ring);
                    hi = cols - 1 - lv;
                    if (hi < lv) begin
                        return 1'b0;
                    end
                    case (leg)
                        LEG_RIGHT: begin
                            if (c < hi) c++;
                            else begin
                                leg = LEG_DOWN;
                                r++;
                            end
                        end
                        LEG_DOWN: begin
                            if (r < hi) r++;
                            else begin
                                leg = LEG_LEFT;
                                c--;
                            end
                        end
                        LEG_LEFT: begin
                            if (c > lv) c--;
                            else begin
                                leg = LEG_UP;
                                r--;
                            end
                        end
                        default: begin
                            if (r > lv + 1) r--;
                            else begin
                                ring = IDX_W'(lv + 1);
                                leg  = LEG_RIGHT;
                                c++;
                            end
                        end
                    endcase
                end
                MODE_SNAKE: begin
                    if ((r & 1) == 0) begin
                        if (c < cols - 1) c++;
                        else r++;
                    end else begin
                        if (c > 0) c--;
                        else r++;
                    end
                end
                MODE_ZIG_RIGHT, MODE_ZIG_DOWN: begin
                    d = r + c;
                    down_left = ((d & 1) == 1) == (scan == MODE_ZIG_RIGHT);
                    if (down_left && c > 0 && r + 1 < rows) begin
                        r++;
                        c--;
                    end else if (!down_left && r > 0 && c + 1 < cols) begin
                        r--;
                        c++;
                    end else begin
                        // The next diagonal starts at its first cell inside the matrix.
                        d++;
                        if (down_left) begin
                            r = (d < rows - 1) ? d : rows - 1;
                            c = d - r;
                        end else begin
                            c = (d < cols - 1) ? d : cols - 1;
                            r = d - c;
                        end
                    end
                end
                default: begin
                    if (c < cols - 1) c++;
                    else begin
                        c = 0;
                        r++;
                    end
                end
            endcase
            if (r < 0 || c < 0 || r >= rows || c >= cols) begin
                return 1'b0;
            end
            r_out = r;
            c_out = c;
            return 1'b1;
        endfunction

        function void note_beat(logic restart);
            t_scan_mode scan;
            int         rows;
            int         cols;
            int         total;
            int         r;
            int         c;
            bit         fresh;
            t_cell_beat beat;
            scan  = (mode_reg <= 3'd4) ? t_scan_mode'(mode_reg) : MODE_RASTER;
            cols  = used_dim(cols_reg);
            rows  = (scan == MODE_SPIRAL) ? cols : used_dim(rows_reg);
            total = rows * cols;
            r = 0;
            c = 0;
            fresh = restart || !begun || (int'(seq) + 1 >= total);
            if (!fresh) begin
                if (!advance(scan, rows, cols, r, c)) fresh = 1'b1;
            end
            if (fresh) begin
                r    = 0;
                c    = 0;
                seq  = '0;
                ring = '0;
                leg  = LEG_RIGHT;
            end else begin
                seq = seq + 1'b1;
            end
            row_pos = IDX_W'(r);
            col_pos = IDX_W'(c);
            diag    = 5'(r + c);
            begun   = 1'b1;
            beat.row   = row_pos;
            beat.col   = col_pos;
            beat.value = start_reg + DATA_W'(seq);
            beat.last  = (int'(seq) + 1 == total);
            pending.push_back(beat);
        endfunction

        function void check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                   logic [DATA_W-1:0] value, logic last);
            t_cell_beat beat;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: row %0d col %0d value %h last %0b",
                             row, col, value, last);
                return;
            end
            beat = pending.pop_front();
            if (beat.row !== row || beat.col !== col || beat.value !== value ||
                beat.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("beat mismatch: expected row %0d col %0d value %h last %0b, %s",
                             beat.row, beat.col, beat.value, beat.last,
                             $sformatf("got row %0d col %0d value %h last %0b",
                                       row, col, value, last));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_restart;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [IDX_W-1:0]  o_row_index;
    logic [IDX_W-1:0]  o_col_index;
    logic signed [DATA_W-1:0] o_cell_value;
    logic              o_last_cell;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    scan_scoreboard sb;
    bit             in_calm;
    bit             out_calm;

    matrix_scan_order_generator_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_cell_value (o_cell_value),
        .o_last_cell  (o_last_cell),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Both handshakes are judged on the values present just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_row_index, o_col_index, o_cell_value, o_last_cell);
            if (i_in_valid && !o_in_stall)
                sb.note_beat(i_restart);
        end
    end

    initial begin
        int unsigned hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            hold = out_calm ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_beat(logic restart);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_addr which, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(which));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(which, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_all(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                           logic [DATA_W-1:0] first, logic [2:0] mode);
        write_reg(REG_ROW_COUNT, DATA_W'(rows));
        write_reg(REG_COL_COUNT, DATA_W'(cols));
        write_reg(REG_START_VALUE, first);
        write_reg(REG_SCAN_MODE, DATA_W'(mode));
    endtask

    // Mostly small matrices so that scans complete often; sometimes out-of-range sizes.
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 7) return DIM_W'($urandom_range(1, 5));
        if (k < 9) return DIM_W'($urandom_range(6, MAX_DIM));
        return $urandom_range(0, 1) ? DIM_W'(0) : DIM_W'($urandom_range(MAX_DIM + 1, 31));
    endfunction

    initial begin
        int          sent;
        int          n;
        int          phase;
        int unsigned k;
        logic [DATA_W-1:0] first;
        logic [2:0]  mode;
        sb = new();
        in_calm  = 1'b0;
        out_calm = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_restart  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings; the first beat begins a scan even without restart.
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
        drain();
        // Zero sizes count as one: every beat is a one-cell scan.
        set_all('0, '0, 32'h7FFF_FFFF, MODE_RASTER);
        repeat (2) send_beat(1'b0);
        drain();
        // Oversized column count; the value wraps past the top of 32 bits.
        set_all(DIM_W'(1), DIM_W'(31), 32'hFFFF_FFFF, MODE_ZIG_RIGHT);
        repeat (2) send_beat(1'b0);
        drain();
        set_all(DIM_W'(2), DIM_W'(2), 32'h8000_0000, UNKNOWN_MODE);
        repeat (3) send_beat(1'b0);
        drain();
        // Spiral ignores the row count.
        set_all(DIM_W'(9), DIM_W'(3), '0, MODE_SPIRAL);
        repeat (9) send_beat(1'b0);
        drain();
        set_all(DIM_W'(3), DIM_W'(2), 32'h0000_0100, MODE_SNAKE);
        repeat (3) send_beat(1'b0);
        drain();
        set_all(DIM_W'(3), DIM_W'(2), 32'hFFFF_FF00, MODE_ZIG_DOWN);
        repeat (2) send_beat(1'b0);
        drain();

        // One full scan at the largest size.
        set_all(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), $urandom, MODE_SPIRAL);
        for (n = 0; n < MAX_DIM * MAX_DIM + 4; n++) send_beat(1'b0);
        sent = MAX_DIM * MAX_DIM + 4;

        phase = 0;
        while (sent < 800) begin
            drain();
            k = $urandom_range(0, 5);
            case (k)
                0:       first = 32'h8000_0000;
                1:       first = 32'h7FFF_FFFF - $urandom_range(0, 20);
                2:       first = 32'hFFFF_FFFF - $urandom_range(0, 20);
                default: first = $urandom;
            endcase
            mode = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            if (phase % 4 == 0) begin
                set_all(pick_dim(), pick_dim(), first, mode);
            end else begin
                if ($urandom_range(0, 1)) write_reg(REG_ROW_COUNT, DATA_W'(pick_dim()));
                if ($urandom_range(0, 1)) write_reg(REG_COL_COUNT, DATA_W'(pick_dim()));
                if ($urandom_range(0, 2) == 0) write_reg(REG_START_VALUE, first);
                write_reg(REG_SCAN_MODE, DATA_W'(mode));
            end
            n = $urandom_range(8, 48);
            repeat (n) begin
                // An occasional restart breaks a scan in the middle.
                send_beat($urandom_range(0, 31) == 0);
                if ($urandom_range(0, 99) == 0) drain();
            end
            sent += n;
            phase++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/msog_pkg.sv
hdl/matrix_scan_order_generator_top.sv
bench/testbench.sv
